### rtl/kmp_pkg.sv
// Shared types, constants and helper functions for the KTX header and mip parser.
`timescale 1ns / 1ps
package kmp_pkg;

  // Parse phases
  typedef enum logic [2:0] {
    PH_IDENT  = 3'd0,
    PH_ENDIAN = 3'd1,
    PH_HEADER = 3'd2,
    PH_SKIP   = 3'd3,
    PH_SIZE   = 3'd4
  } phase_t;

  // Record kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_LEVEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SHORT    = 3'd1;
  localparam logic [2:0] ERR_IDENT    = 3'd2;
  localparam logic [2:0] ERR_ENDIAN   = 3'd3;
  localparam logic [2:0] ERR_KEYVALUE = 3'd4;
  localparam logic [2:0] ERR_SIZEWORD = 3'd5;
  localparam logic [2:0] ERR_LEVELDAT = 3'd6;

  // Header layout
  localparam logic [31:0] HDR_BYTES     = 32'd64;
  localparam logic [31:0] IDENT_LAST    = 32'd11;
  localparam logic [31:0] ENDIAN_LAST   = 32'd15;
  localparam logic [31:0] POS_FORMAT    = 32'd31;
  localparam logic [31:0] POS_WIDTH     = 32'd39;
  localparam logic [31:0] POS_HEIGHT    = 32'd43;
  localparam logic [31:0] POS_LEVELS    = 32'd59;
  localparam logic [31:0] POS_KEYVALUE  = 32'd63;
  localparam logic [31:0] MARK_LITTLE   = 32'h04030201;
  localparam logic [31:0] MARK_BIG      = 32'h01020304;

  // One word from the input stage to the parse core
  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_buffer;
  } item_t;

  // One result record
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  error_code;
    logic [31:0] level_index;
    logic [31:0] level_count;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [31:0] level_width;
    logic [31:0] level_height;
    logic [31:0] format_code;
    logic        final_res;
  } res_t;

  // File identifier bytes
  function automatic logic [7:0] ident_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'hAB;
      4'd1:    v = 8'h4B;
      4'd2:    v = 8'h54;
      4'd3:    v = 8'h58;
      4'd4:    v = 8'h20;
      4'd5:    v = 8'h31;
      4'd6:    v = 8'h31;
      4'd7:    v = 8'hBB;
      4'd8:    v = 8'h0D;
      4'd9:    v = 8'h0A;
      4'd10:   v = 8'h1A;
      4'd11:   v = 8'h0A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Shift one byte into the word in the selected byte order
  function automatic logic [31:0] shift_word(input logic [31:0] w, input logic [7:0] b,
                                             input logic big);
    logic [31:0] v;
    if (big) begin
      v = {w[23:0], b};
    end else begin
      v = {b, w[31:8]};
    end
    return v;
  endfunction

  // Halve the base dimension per level, never below 1
  function automatic logic [31:0] level_dim(input logic [31:0] base, input logic [31:0] lvl);
    logic [31:0] v;
    if (lvl == 32'd0) begin
      v = base;
    end else if (lvl[31:5] != 27'd0) begin
      v = 32'd1;
    end else begin
      v = base >> lvl[4:0];
      if (v == 32'd0) begin
        v = 32'd1;
      end
    end
    return v;
  endfunction

endpackage

### rtl/kmp_in_stage.sv
// Input register stage of the KTX parser: captures one byte word per cycle unless stalled.
`timescale 1ns / 1ps
module kmp_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte_value,
  input  logic           in_start_of_buffer,
  input  logic           out_free,
  output logic           item_valid,
  output logic           item_fire,
  output kmp_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  kmp_pkg::item_t item_r;
  logic           accept;

  // Stall only while a held word cannot move on
  assign item_fire  = valid_r && out_free;
  assign in_stall   = valid_r && !out_free;
  assign accept     = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Advance or drop the held word
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.byte_value      <= in_byte_value;
      item_r.start_of_buffer <= in_start_of_buffer;
    end
  end

endmodule

### rtl/kmp_parse_core.sv
// Parse state and per-byte decode logic of the KTX parser.
`timescale 1ns / 1ps
module kmp_parse_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_fire,
  input  kmp_pkg::item_t item,
  input  logic [31:0]    buffer_length,
  output logic           res_valid,
  output kmp_pkg::res_t  res
);

  logic [31:0]      pos_r,   pos_nxt,   pos_c;
  kmp_pkg::phase_t  phase_r, phase_nxt, phase_c;
  logic [31:0]      word_r,  word_nxt,  word_c;
  logic             big_r,   big_nxt,   big_c;
  logic [31:0]      bw_r,    bw_nxt,    bw_c;
  logic [31:0]      bh_r,    bh_nxt,    bh_c;
  logic [31:0]      fmt_r,   fmt_nxt,   fmt_c;
  logic [31:0]      lvt_r,   lvt_nxt,   lvt_c;
  logic [31:0]      kvl_r,   kvl_nxt,   kvl_c;
  logic [31:0]      lvl_r,   lvl_nxt,   lvl_c;
  logic [32:0]      nfo_r,   nfo_nxt,   nfo_c;
  logic             stop_r,  stop_nxt,  stop_c;

  logic [7:0]       b;
  logic [35:0]      len;
  logic [35:0]      kv_end;
  logic [35:0]      data_off;
  logic [35:0]      data_end;
  logic [35:0]      next_off;
  logic [1:0]       pad;
  logic             last;
  kmp_pkg::phase_t  ph;

  // Restart clears parse state ahead of this byte
  always_comb begin
    b   = item.byte_value;
    len = {4'd0, buffer_length};
    if (item.start_of_buffer) begin
      pos_c   = '0;
      phase_c = kmp_pkg::PH_IDENT;
      word_c  = '0;
      big_c   = 1'b0;
      bw_c    = '0;
      bh_c    = '0;
      fmt_c   = '0;
      lvt_c   = '0;
      kvl_c   = '0;
      lvl_c   = '0;
      nfo_c   = '0;
      stop_c  = 1'b0;
    end else begin
      pos_c   = pos_r;
      phase_c = phase_r;
      word_c  = word_r;
      big_c   = big_r;
      bw_c    = bw_r;
      bh_c    = bh_r;
      fmt_c   = fmt_r;
      lvt_c   = lvt_r;
      kvl_c   = kvl_r;
      lvl_c   = lvl_r;
      nfo_c   = nfo_r;
      stop_c  = stop_r;
    end
  end

  // Decode one byte
  always_comb begin
    pos_nxt   = pos_c;
    phase_nxt = phase_c;
    word_nxt  = word_c;
    big_nxt   = big_c;
    bw_nxt    = bw_c;
    bh_nxt    = bh_c;
    fmt_nxt   = fmt_c;
    lvt_nxt   = lvt_c;
    kvl_nxt   = kvl_c;
    lvl_nxt   = lvl_c;
    nfo_nxt   = nfo_c;
    stop_nxt  = stop_c;
    res_valid = 1'b0;
    res       = '0;
    ph        = phase_c;
    kv_end    = '0;
    data_off  = '0;
    data_end  = '0;
    next_off  = '0;
    pad       = '0;
    last      = 1'b0;

    if (!stop_c) begin
      pos_nxt = pos_c + 32'd1;
      case (phase_c)
        kmp_pkg::PH_IDENT: begin
          if (pos_c == 32'd0 && buffer_length < kmp_pkg::HDR_BYTES) begin
            res_valid      = 1'b1;
            res.record_kind = kmp_pkg::KIND_ERROR;
            res.error_code = kmp_pkg::ERR_SHORT;
            res.final_res  = 1'b1;
            stop_nxt       = 1'b1;
          end else if (pos_c > kmp_pkg::IDENT_LAST || b != kmp_pkg::ident_byte(pos_c[3:0])) begin
            res_valid      = 1'b1;
            res.record_kind = kmp_pkg::KIND_ERROR;
            res.error_code = kmp_pkg::ERR_IDENT;
            res.final_res  = 1'b1;
            stop_nxt       = 1'b1;
          end else if (pos_c == kmp_pkg::IDENT_LAST) begin
            phase_nxt = kmp_pkg::PH_ENDIAN;
          end
        end

        kmp_pkg::PH_ENDIAN: begin
          word_nxt = kmp_pkg::shift_word(word_c, b, 1'b0);
          if (pos_c >= kmp_pkg::ENDIAN_LAST) begin
            if (word_nxt == kmp_pkg::MARK_LITTLE) begin
              big_nxt   = 1'b0;
              phase_nxt = kmp_pkg::PH_HEADER;
            end else if (word_nxt == kmp_pkg::MARK_BIG) begin
              big_nxt   = 1'b1;
              phase_nxt = kmp_pkg::PH_HEADER;
            end else begin
              res_valid      = 1'b1;
              res.record_kind = kmp_pkg::KIND_ERROR;
              res.error_code = kmp_pkg::ERR_ENDIAN;
              res.final_res  = 1'b1;
              stop_nxt       = 1'b1;
            end
          end
        end

        kmp_pkg::PH_HEADER: begin
          word_nxt = kmp_pkg::shift_word(word_c, b, big_c);
          // Latch the header words we keep
          if (pos_c == kmp_pkg::POS_FORMAT) begin
            fmt_nxt = word_nxt;
          end
          if (pos_c == kmp_pkg::POS_WIDTH) begin
            bw_nxt = word_nxt;
          end
          if (pos_c == kmp_pkg::POS_HEIGHT) begin
            bh_nxt = word_nxt;
          end
          if (pos_c == kmp_pkg::POS_LEVELS) begin
            lvt_nxt = (word_nxt == 32'd0) ? 32'd1 : word_nxt;
          end
          if (pos_c == kmp_pkg::POS_KEYVALUE) begin
            kvl_nxt = word_nxt;
          end
          // End of header: check bounds, give the header record or an error record
          if (pos_c >= kmp_pkg::POS_KEYVALUE) begin
            if (lvt_nxt == 32'd0) begin
              lvt_nxt = 32'd1;
            end
            kv_end = {4'd0, kmp_pkg::HDR_BYTES} + {4'd0, kvl_nxt};
            if (kv_end > len) begin
              res_valid      = 1'b1;
              res.record_kind = kmp_pkg::KIND_ERROR;
              res.error_code = kmp_pkg::ERR_KEYVALUE;
              res.final_res  = 1'b1;
              stop_nxt       = 1'b1;
            end else if (kv_end + 36'd4 > len) begin
              res_valid      = 1'b1;
              res.record_kind = kmp_pkg::KIND_ERROR;
              res.error_code = kmp_pkg::ERR_SIZEWORD;
              res.final_res  = 1'b1;
              stop_nxt       = 1'b1;
            end else begin
              res_valid           = 1'b1;
              res.record_kind     = kmp_pkg::KIND_HEADER;
              res.error_code      = kmp_pkg::ERR_NONE;
              res.level_count     = lvt_nxt;
              res.data_offset     = kv_end[31:0];
              res.data_size       = kvl_nxt;
              res.level_width     = bw_nxt;
              res.level_height    = bh_nxt;
              res.format_code     = fmt_nxt;
              lvl_nxt             = '0;
              nfo_nxt             = kv_end[32:0];
              phase_nxt           = kmp_pkg::PH_SKIP;
            end
          end
        end

        kmp_pkg::PH_SKIP, kmp_pkg::PH_SIZE: begin
          // Leave the skip once the next size word starts
          if (phase_c == kmp_pkg::PH_SKIP && {1'b0, pos_c} >= nfo_c) begin
            ph = kmp_pkg::PH_SIZE;
          end
          phase_nxt = ph;
          if (ph == kmp_pkg::PH_SIZE) begin
            word_nxt = kmp_pkg::shift_word(word_c, b, big_c);
            if ({4'd0, pos_c} >= {3'd0, nfo_c} + 36'd3) begin
              data_off = {3'd0, nfo_c} + 36'd4;
              data_end = data_off + {4'd0, word_nxt};
              pad      = 2'd0 - word_nxt[1:0];
              next_off = data_end + {34'd0, pad};
              last     = (lvl_c >= lvt_c - 32'd1);
              if (data_end > len) begin
                res_valid       = 1'b1;
                res.record_kind = kmp_pkg::KIND_ERROR;
                res.error_code  = kmp_pkg::ERR_LEVELDAT;
                res.level_index = lvl_c;
                res.final_res   = 1'b1;
                stop_nxt        = 1'b1;
              end else if (!last && next_off + 36'd4 > len) begin
                res_valid       = 1'b1;
                res.record_kind = kmp_pkg::KIND_ERROR;
                res.error_code  = kmp_pkg::ERR_SIZEWORD;
                res.level_index = lvl_c + 32'd1;
                res.final_res   = 1'b1;
                stop_nxt        = 1'b1;
              end else begin
                res_valid           = 1'b1;
                res.record_kind     = kmp_pkg::KIND_LEVEL;
                res.error_code      = kmp_pkg::ERR_NONE;
                res.level_index     = lvl_c;
                res.level_count     = lvt_c;
                res.data_offset     = data_off[31:0];
                res.data_size       = word_nxt;
                res.level_width     = kmp_pkg::level_dim(bw_c, lvl_c);
                res.level_height    = kmp_pkg::level_dim(bh_c, lvl_c);
                res.format_code     = fmt_c;
                res.final_res       = last;
                if (last) begin
                  stop_nxt = 1'b1;
                end else begin
                  lvl_nxt   = lvl_c + 32'd1;
                  nfo_nxt   = next_off[32:0];
                  phase_nxt = kmp_pkg::PH_SKIP;
                end
              end
            end
          end
        end

        default: begin
          pos_nxt = pos_c;
        end
      endcase
    end
  end

  // Hold or advance the parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= kmp_pkg::PH_IDENT;
      word_r  <= '0;
      big_r   <= 1'b0;
      bw_r    <= '0;
      bh_r    <= '0;
      fmt_r   <= '0;
      lvt_r   <= '0;
      kvl_r   <= '0;
      lvl_r   <= '0;
      nfo_r   <= '0;
      stop_r  <= 1'b0;
    end else if (item_fire) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      word_r  <= word_nxt;
      big_r   <= big_nxt;
      bw_r    <= bw_nxt;
      bh_r    <= bh_nxt;
      fmt_r   <= fmt_nxt;
      lvt_r   <= lvt_nxt;
      kvl_r   <= kvl_nxt;
      lvl_r   <= lvl_nxt;
      nfo_r   <= nfo_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

### rtl/kmp_out_stage.sv
// Result register stage of the KTX parser: holds one record until taken.
`timescale 1ns / 1ps
module kmp_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_fire,
  input  logic          res_valid,
  input  kmp_pkg::res_t res,
  output logic          out_free,
  output logic          out_valid,
  input  logic          out_stall,
  output kmp_pkg::res_t out_res
);

  logic          valid_r;
  logic          valid_nxt;
  kmp_pkg::res_t res_r;

  // Register can take a new word when empty or being drained
  assign out_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (out_free) begin
      valid_nxt = item_fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load a fresh record
  always_ff @(posedge clk) begin
    if (item_fire && res_valid) begin
      res_r <= res;
    end
  end

endmodule

### rtl/ktx_header_mip_parser.sv
// Top level of the streaming KTX texture container header and mip level parser.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------
//   in_     | input     | in_valid/in_stall  | byte_value, start_of_buffer
//   out_    | output    | out_valid/out_stall| record_kind .. final_res (one record)
//   cfg_    | input     | cfg_valid/cfg_ready| buffer_length
//
// One byte word is taken every cycle while the input is not stalled; a record for a
// byte passes the input register, the decode and the result register. Throughput is
// set by the single decode pass between those registers. Reset clears all parse state
// and the buffer length to zero. A stalled result register stalls the input only once
// the input register also holds a word; cfg_ready is always high.
`timescale 1ns / 1ps
module ktx_header_mip_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_start_of_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [2:0]  out_error_code,
  output logic [31:0] out_level_index,
  output logic [31:0] out_level_count,
  output logic [31:0] out_data_offset,
  output logic [31:0] out_data_size,
  output logic [31:0] out_level_width,
  output logic [31:0] out_level_height,
  output logic [31:0] out_format_code,
  output logic        out_final_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_buffer_length
);

  logic           out_free;
  logic           item_valid;
  logic           item_fire;
  kmp_pkg::item_t item;
  logic           res_valid;
  kmp_pkg::res_t  res;
  kmp_pkg::res_t  out_res;
  logic [31:0]    buffer_length_r;

  // Buffer length register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      buffer_length_r <= cfg_buffer_length;
    end
  end

  kmp_in_stage u_in (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte_value      (in_byte_value),
    .in_start_of_buffer (in_start_of_buffer),
    .out_free           (out_free),
    .item_valid         (item_valid),
    .item_fire          (item_fire),
    .item               (item)
  );

  kmp_parse_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_fire     (item_fire && item_valid),
    .item          (item),
    .buffer_length (buffer_length_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  kmp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (item_fire),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Unpack the result word
  assign out_record_kind     = out_res.record_kind;
  assign out_error_code      = out_res.error_code;
  assign out_level_index     = out_res.level_index;
  assign out_level_count     = out_res.level_count;
  assign out_data_offset     = out_res.data_offset;
  assign out_data_size       = out_res.data_size;
  assign out_level_width     = out_res.level_width;
  assign out_level_height    = out_res.level_height;
  assign out_format_code     = out_res.format_code;
  assign out_final_res       = out_res.final_res;

endmodule

### tb/tb_ktx_header_mip_parser.sv
// Self-checking testbench for the KTX container header and mip level parser.
`timescale 1ns / 1ps
module tb_ktx_header_mip_parser;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  // File identifier, byte 0 in the top byte
  localparam logic [95:0] ID_SEQ = 96'hAB4B5458_203131BB_0D0A1A0A;

  // Header word slots after the endianness marker
  localparam int SLOT_FORMAT   = 3;
  localparam int SLOT_WIDTH    = 5;
  localparam int SLOT_HEIGHT   = 6;
  localparam int SLOT_LEVELS   = 10;
  localparam int SLOT_KEYVALUE = 11;

  // Predicts the records of the parser and matches them against the ones it gives
  class ktx_record_tracker;
    logic [31:0]     buf_len;
    kmp_pkg::phase_t phase;
    logic [31:0]     pos;
    logic [31:0]     word;
    bit              big;
    logic [31:0]     width;
    logic [31:0]     height;
    logic [31:0]     fmt;
    logic [31:0]     levels;
    logic [31:0]     kv_len;
    logic [31:0]     cur_lvl;
    logic [63:0]     next_off;
    bit              stopped;
    kmp_pkg::res_t   pending_records[$];
    int              mismatches;
    int              header_hits;
    int              level_hits;
    int              error_hits[8];

    function new();
      buf_len = '0;
      mismatches = 0;
      header_hits = 0;
      level_hits = 0;
      foreach (error_hits[i]) error_hits[i] = 0;
      restart();
    endfunction

    // Clear the parse, keep the buffer length
    function void restart();
      phase = kmp_pkg::PH_IDENT;
      pos = '0;
      word = '0;
      big = 1'b0;
      width = '0;
      height = '0;
      fmt = '0;
      levels = '0;
      kv_len = '0;
      cur_lvl = '0;
      next_off = '0;
      stopped = 1'b0;
    endfunction

    function void set_length(logic [31:0] len);
      buf_len = len;
    endfunction

    function void shift_in(logic [7:0] val, bit msb_first);
      word = msb_first ? {word[23:0], val} : {val, word[31:8]};
    endfunction

    function logic [31:0] halved(logic [31:0] base, logic [31:0] lvl);
      logic [31:0] v;
      if (lvl == 0) return base;
      if (lvl >= 32) return 32'd1;
      v = base >> lvl;
      return (v == 0) ? 32'd1 : v;
    endfunction

    function kmp_pkg::res_t fail_record(logic [2:0] code, logic [31:0] lvl);
      kmp_pkg::res_t r;
      r = '0;
      r.record_kind = kmp_pkg::KIND_ERROR;
      r.error_code = code;
      r.level_index = lvl;
      r.final_res = 1'b1;
      stopped = 1'b1;
      return r;
    endfunction

    // Advance the parse by one accepted byte word; returns 0 if the byte is ignored
    function bit take_byte(logic [7:0] val, bit sob);
      kmp_pkg::res_t r;
      bit            emit;
      bit            final_lvl;
      logic [63:0]   len;
      logic [63:0]   kv_end;
      logic [63:0]   data_off;
      logic [63:0]   nxt;
      logic [31:0]   lvl_bytes;
      logic [1:0]    pad;
      if (sob) restart();
      if (stopped) return 1'b0;
      r = '0;
      emit = 1'b0;
      len = {32'd0, buf_len};
      case (phase)
        kmp_pkg::PH_IDENT: begin
          if (pos == 0 && len < {32'd0, kmp_pkg::HDR_BYTES}) begin
            r = fail_record(kmp_pkg::ERR_SHORT, 32'd0);
            emit = 1'b1;
          end else if (pos > kmp_pkg::IDENT_LAST ||
                       val != ID_SEQ[8 * (11 - pos[3:0]) +: 8]) begin
            r = fail_record(kmp_pkg::ERR_IDENT, 32'd0);
            emit = 1'b1;
          end else if (pos == kmp_pkg::IDENT_LAST) begin
            phase = kmp_pkg::PH_ENDIAN;
          end
        end
        kmp_pkg::PH_ENDIAN: begin
          shift_in(val, 1'b0);
          if (pos >= kmp_pkg::ENDIAN_LAST) begin
            if (word == kmp_pkg::MARK_LITTLE) begin
              big = 1'b0;
              phase = kmp_pkg::PH_HEADER;
            end else if (word == kmp_pkg::MARK_BIG) begin
              big = 1'b1;
              phase = kmp_pkg::PH_HEADER;
            end else begin
              r = fail_record(kmp_pkg::ERR_ENDIAN, 32'd0);
              emit = 1'b1;
            end
          end
        end
        kmp_pkg::PH_HEADER: begin
          shift_in(val, big);
          case (pos)
            kmp_pkg::POS_FORMAT:   fmt = word;
            kmp_pkg::POS_WIDTH:    width = word;
            kmp_pkg::POS_HEIGHT:   height = word;
            kmp_pkg::POS_LEVELS:   levels = (word == 0) ? 32'd1 : word;
            kmp_pkg::POS_KEYVALUE: kv_len = word;
            default: ;
          endcase
          if (pos >= kmp_pkg::HDR_BYTES - 1) begin
            kv_end = {32'd0, kmp_pkg::HDR_BYTES} + {32'd0, kv_len};
            if (levels == 0) levels = 32'd1;
            if (kv_end > len) begin
              r = fail_record(kmp_pkg::ERR_KEYVALUE, 32'd0);
            end else if (kv_end + 4 > len) begin
              r = fail_record(kmp_pkg::ERR_SIZEWORD, 32'd0);
            end else begin
              r.record_kind = kmp_pkg::KIND_HEADER;
              r.error_code = kmp_pkg::ERR_NONE;
              r.level_count = levels;
              r.data_offset = kv_end[31:0];
              r.data_size = kv_len;
              r.level_width = width;
              r.level_height = height;
              r.format_code = fmt;
              cur_lvl = '0;
              next_off = kv_end;
              phase = kmp_pkg::PH_SKIP;
            end
            emit = 1'b1;
          end
        end
        default: begin
          // Skip key-value, image and padding bytes up to the next size word
          if (phase == kmp_pkg::PH_SKIP && {32'd0, pos} >= next_off) phase = kmp_pkg::PH_SIZE;
          if (phase == kmp_pkg::PH_SIZE) begin
            shift_in(val, big);
            if ({32'd0, pos} >= next_off + 3) begin
              lvl_bytes = word;
              pad = 2'd0 - lvl_bytes[1:0];
              data_off = next_off + 4;
              nxt = data_off + {32'd0, lvl_bytes} + {62'd0, pad};
              final_lvl = (cur_lvl >= levels - 1);
              if (data_off + {32'd0, lvl_bytes} > len) begin
                r = fail_record(kmp_pkg::ERR_LEVELDAT, cur_lvl);
              end else if (!final_lvl && nxt + 4 > len) begin
                r = fail_record(kmp_pkg::ERR_SIZEWORD, cur_lvl + 1);
              end else begin
                r.record_kind = kmp_pkg::KIND_LEVEL;
                r.error_code = kmp_pkg::ERR_NONE;
                r.level_index = cur_lvl;
                r.level_count = levels;
                r.data_offset = data_off[31:0];
                r.data_size = lvl_bytes;
                r.level_width = halved(width, cur_lvl);
                r.level_height = halved(height, cur_lvl);
                r.format_code = fmt;
                r.final_res = final_lvl;
                if (final_lvl) begin
                  stopped = 1'b1;
                end else begin
                  cur_lvl = cur_lvl + 1;
                  next_off = nxt & 64'h1_FFFF_FFFF;
                  phase = kmp_pkg::PH_SKIP;
                end
              end
              emit = 1'b1;
            end
          end
        end
      endcase
      if (emit) pending_records.push_back(r);
      pos = pos + 1;
      return 1'b1;
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Match one accepted record word against the oldest prediction
    function void match_record(kmp_pkg::res_t got);
      kmp_pkg::res_t want;
      if (pending_records.size() == 0) begin
        mismatches++;
        $display("%0t: record expected none, actual kind %0d code %0d", $time,
                 got.record_kind, got.error_code);
        return;
      end
      want = pending_records.pop_front();
      check_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
      check_field("error_code", 32'(want.error_code), 32'(got.error_code));
      check_field("level_index", want.level_index, got.level_index);
      check_field("level_count", want.level_count, got.level_count);
      check_field("data_offset", want.data_offset, got.data_offset);
      check_field("data_size", want.data_size, got.data_size);
      check_field("level_width", want.level_width, got.level_width);
      check_field("level_height", want.level_height, got.level_height);
      check_field("format_code", want.format_code, got.format_code);
      check_field("final_res", 32'(want.final_res), 32'(got.final_res));
      case (want.record_kind)
        kmp_pkg::KIND_HEADER: header_hits++;
        kmp_pkg::KIND_LEVEL:  level_hits++;
        default:              error_hits[want.error_code]++;
      endcase
    endfunction

    // Count records still owed at the end as failures
    function int leftover_failures();
      if (pending_records.size() != 0)
        $display("%0t: %0d records expected, actual none", $time, pending_records.size());
      return mismatches + pending_records.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = '0;
  logic        in_start_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_record_kind;
  logic [2:0]  out_error_code;
  logic [31:0] out_level_index;
  logic [31:0] out_level_count;
  logic [31:0] out_data_offset;
  logic [31:0] out_data_size;
  logic [31:0] out_level_width;
  logic [31:0] out_level_height;
  logic [31:0] out_format_code;
  logic        out_final_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_buffer_length = '0;

  ktx_record_tracker tracker = new();

  int            send_idle_pct = 0;
  int            stall_pct = 0;
  int            hold_requests = 0;
  int            hold_served = 0;
  int            hold_left = 0;
  int            quiet_cycles = 0;
  int            backpressure_cycles = 0;
  int            parsed_bytes = 0;
  int            sent_bytes = 0;
  int            length_settings = 0;
  logic [7:0]    frame_bytes[$];
  logic [31:0]   level_sizes[$];
  kmp_pkg::res_t seen_rec;

  ktx_header_mip_parser i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte_value      (in_byte_value),
    .in_start_of_buffer (in_start_of_buffer),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_record_kind    (out_record_kind),
    .out_error_code     (out_error_code),
    .out_level_index    (out_level_index),
    .out_level_count    (out_level_count),
    .out_data_offset    (out_data_offset),
    .out_data_size      (out_data_size),
    .out_level_width    (out_level_width),
    .out_level_height   (out_level_height),
    .out_format_code    (out_format_code),
    .out_final_res      (out_final_res),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_buffer_length  (cfg_buffer_length)
  );

  always #5 clk = ~clk;

  // Stall the record channel at random, or hold it off for a long stretch on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check every accepted record word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_rec.record_kind = out_record_kind;
      seen_rec.error_code = out_error_code;
      seen_rec.level_index = out_level_index;
      seen_rec.level_count = out_level_count;
      seen_rec.data_offset = out_data_offset;
      seen_rec.data_size = out_data_size;
      seen_rec.level_width = out_level_width;
      seen_rec.level_height = out_level_height;
      seen_rec.format_code = out_format_code;
      seen_rec.final_res = out_final_res;
      tracker.match_record(seen_rec);
    end
  end

  // End the run if no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) backpressure_cycles <= backpressure_cycles + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_ktx_header_mip_parser NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte word, idling first at random, and wait until it is taken
  task automatic push_byte(input logic [7:0] val, input bit sob);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= val;
    in_start_of_buffer <= sob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
    if (tracker.take_byte(val, sob)) parsed_bytes++;
  endtask

  // Drop the input, wait for all owed records, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [31:0] len);
    settle();
    cfg_valid <= 1'b1;
    cfg_buffer_length <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.set_length(len);
    length_settings++;
  endtask

  function automatic void put_word(logic [31:0] v, bit msb_first);
    if (msb_first) begin
      for (int i = 3; i >= 0; i--) frame_bytes.push_back(v[8 * i +: 8]);
    end else begin
      for (int i = 0; i < 4; i++) frame_bytes.push_back(v[8 * i +: 8]);
    end
  endfunction

  // Build a container with one size word per entry of level_sizes
  function automatic void build_frame(bit msb_first, logic [31:0] fmt, logic [31:0] w,
                                      logic [31:0] h, logic [31:0] lvl_field,
                                      logic [31:0] kv);
    logic [31:0] hdr_word;
    int unsigned fill;
    frame_bytes.delete();
    for (int i = 11; i >= 0; i--) frame_bytes.push_back(ID_SEQ[8 * i +: 8]);
    put_word(kmp_pkg::MARK_LITTLE, msb_first);
    for (int k = 0; k < 12; k++) begin
      case (k)
        SLOT_FORMAT:   hdr_word = fmt;
        SLOT_WIDTH:    hdr_word = w;
        SLOT_HEIGHT:   hdr_word = h;
        SLOT_LEVELS:   hdr_word = lvl_field;
        SLOT_KEYVALUE: hdr_word = kv;
        default:       hdr_word = $urandom();
      endcase
      put_word(hdr_word, msb_first);
    end
    fill = (kv > 64) ? 64 : kv;
    repeat (fill) frame_bytes.push_back(8'($urandom_range(255)));
    foreach (level_sizes[i]) begin
      put_word(level_sizes[i], msb_first);
      fill = (level_sizes[i] > 64) ? 64 : level_sizes[i] + ((4 - level_sizes[i] % 4) % 4);
      repeat (fill) frame_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void random_frame();
    logic [31:0] lvl;
    logic [31:0] w;
    logic [31:0] h;
    level_sizes.delete();
    lvl = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1, 5);
    repeat ((lvl == 0) ? 1 : lvl) level_sizes.push_back($urandom_range(20));
    w = $urandom_range(1) ? $urandom() : $urandom_range(64);
    h = $urandom_range(1) ? $urandom() : $urandom_range(64);
    build_frame(1'($urandom_range(1)), $urandom(), w, h, lvl, $urandom_range(12));
  endfunction

  task automatic send_frame(input int count);
    for (int i = 0; i < count; i++) push_byte(frame_bytes[i], i == 0);
  endtask

  task automatic directed_frame(input bit msb_first, input logic [31:0] fmt,
                                input logic [31:0] w, input logic [31:0] h,
                                input logic [31:0] lvl_field, input logic [31:0] kv);
    build_frame(msb_first, fmt, w, h, lvl_field, kv);
    send_frame(frame_bytes.size());
  endtask

  // Mostly well-formed containers, some corrupted or cut short, some stray bytes
  task automatic random_phase(input int idle_v, input int stall_v, input logic [31:0] len,
                              input int budget);
    int unsigned pick;
    int unsigned spot;
    int          cut;
    int          stop_at;
    set_length(len);
    send_idle_pct = idle_v;
    stall_pct <= stall_v;
    stop_at = sent_bytes + budget;
    while (sent_bytes < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 93) begin
        random_frame();
        if (pick >= 75 && pick < 85) begin
          spot = $urandom_range(frame_bytes.size() - 1);
          frame_bytes[spot] = frame_bytes[spot] ^ (8'd1 << $urandom_range(7));
        end
        cut = frame_bytes.size();
        if (pick >= 85) cut = $urandom_range(1, frame_bytes.size() - 1);
        if (cut > stop_at - sent_bytes) cut = stop_at - sent_bytes;
        send_frame(cut);
      end else begin
        repeat ($urandom_range(1, 6))
          push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Short buffer: reset length, then zero, then one below the header size
    push_byte(8'hAB, 1'b1);
    set_length(32'd0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    set_length(32'd63);
    push_byte(8'hAB, 1'b1);

    // Exactly a header: the first size word does not fit
    set_length(32'd64);
    level_sizes = '{32'd0};
    build_frame(1'b0, 32'h8D64, 32'd4, 32'd4, 32'd1, 32'd0);
    send_frame(64);

    set_length(32'hFFFF_FFFF);
    // Identifier and endianness marker mismatches
    build_frame(1'b0, 32'h1, 32'd1, 32'd1, 32'd1, 32'd0);
    frame_bytes[5] = 8'h00;
    send_frame(6);
    build_frame(1'b1, 32'h1, 32'd1, 32'd1, 32'd1, 32'd0);
    frame_bytes[13] = 8'h07;
    send_frame(16);
    // Level count zero read as one, extreme dimensions
    directed_frame(1'b0, 32'h0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0);
    // Big-endian, key-value data, padded image sizes, zero height
    level_sizes = '{32'd1, 32'd2, 32'd3};
    directed_frame(1'b1, 32'hFFFF_FFFF, 32'd8, 32'd0, 32'd3, 32'd5);
    // Key-value end past the buffer, and the first size word past it, without wrap
    level_sizes = '{32'd0};
    build_frame(1'b0, 32'h2, 32'd2, 32'd2, 32'd1, 32'hFFFF_FFFF);
    send_frame(64);
    build_frame(1'b1, 32'h2, 32'd2, 32'd2, 32'd1, 32'hFFFF_FFBD);
    send_frame(64);
    // Image data past the buffer, then the next size word past it
    level_sizes = '{32'hFFFF_FFFF};
    build_frame(1'b0, 32'h3, 32'd3, 32'd3, 32'd1, 32'd0);
    send_frame(68);
    level_sizes = '{32'hFFFF_FFB8};
    build_frame(1'b1, 32'h3, 32'd3, 32'd3, 32'd2, 32'd0);
    send_frame(68);
    // Restart in the middle of a header
    level_sizes = '{32'd4, 32'd7};
    build_frame(1'b0, 32'h4, 32'd16, 32'd16, 32'd2, 32'd3);
    send_frame(30);
    directed_frame(1'b1, 32'h5, 32'd16, 32'd9, 32'd2, 32'd8);
    // More levels than dimension bits
    level_sizes.delete();
    repeat (40) level_sizes.push_back(32'd0);
    directed_frame(1'b0, 32'h6, 32'hFFFF_FFFF, 32'h8000_0000, 32'd40, 32'd0);
    push_byte(8'hAB, 1'b0);

    // Hold the record channel off while every byte word restarts into an error
    set_length(32'd63);
    hold_requests <= hold_requests + 1;
    repeat (24) push_byte(8'($urandom_range(255)), 1'b1);

    random_phase(0, 0, $urandom_range(150, 400), 90);
    random_phase(52, 0, 32'hFFFF_FFFF, 90);
    random_phase(0, 52, $urandom_range(100, 250), 90);
    random_phase(15, 15, $urandom_range(64, 180), 90);
    settle();

    $display("Covered %0d byte words (%0d parsed) over %0d buffer lengths: %0d header, %0d level",
             sent_bytes, parsed_bytes, length_settings, tracker.header_hits,
             tracker.level_hits);
    $display("Errors short/ident/endian/keyvalue/sizeword/leveldata %0d/%0d/%0d/%0d/%0d/%0d",
             tracker.error_hits[kmp_pkg::ERR_SHORT], tracker.error_hits[kmp_pkg::ERR_IDENT],
             tracker.error_hits[kmp_pkg::ERR_ENDIAN],
             tracker.error_hits[kmp_pkg::ERR_KEYVALUE],
             tracker.error_hits[kmp_pkg::ERR_SIZEWORD],
             tracker.error_hits[kmp_pkg::ERR_LEVELDAT]);
    $display("Input stall cycles %0d", backpressure_cycles);
    if (tracker.leftover_failures() == 0) begin
      $display("tb_ktx_header_mip_parser OK");
    end else begin
      $display("tb_ktx_header_mip_parser NOT OK");
    end
    $finish;
  end

endmodule
